// ===== hw/rtl/ezq_pkg.sv =====
// Shared types and constants for the Euler-to-quaternion pipeline.
`timescale 1ns / 1ps
package ezq_pkg;

  // Half-angle constants in Q30
  localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [32:0] Q30_GAIN    = 33'sd652032874;

  // Rotation state of one angle inside the CORDIC chain
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [33:0] z;
    logic               neg;
  } ezq_rot_t;

  // Word moving down the chain: position words plus roll, pitch, yaw state
  typedef struct packed {
    logic [2:0][31:0] pos;
    ezq_rot_t [2:0]   rot;
  } ezq_pipe_t;

  // Q30 arctangent of 2^-i
  function automatic logic signed [33:0] ezq_atan(input int unsigned i);
    logic signed [33:0] r;
    case (i)
      0:       r = 34'sd843314856;
      1:       r = 34'sd497837829;
      2:       r = 34'sd263043836;
      3:       r = 34'sd133525158;
      4:       r = 34'sd67021686;
      5:       r = 34'sd33543515;
      6:       r = 34'sd16775850;
      7:       r = 34'sd8388437;
      8:       r = 34'sd4194282;
      9:       r = 34'sd2097149;
      default: r = (i <= 30) ? (34'sd1 <<< (30 - i)) : 34'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/ezq_if.sv =====
// Valid/ready channel interfaces for pose words and quaternion words.
`timescale 1ns / 1ps
interface ezq_in_if #(parameter int unsigned ANGLE_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [31:0]            pos_x;
  logic signed [31:0]            pos_y;
  logic signed [31:0]            pos_z;
  logic signed [ANGLE_WIDTH-1:0] roll_angle;
  logic signed [ANGLE_WIDTH-1:0] pitch_angle;
  logic signed [ANGLE_WIDTH-1:0] yaw_angle;
  modport source (output valid, pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle,
                  output ready);
endinterface

interface ezq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, out_pos_x, out_pos_y, out_pos_z,
                  quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, out_pos_x, out_pos_y, out_pos_z,
                  quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ===== hw/rtl/ezq_cell.sv =====
// One CORDIC rotation stage for the three angles, with its own word register.
`timescale 1ns / 1ps
module ezq_cell
  import ezq_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  ezq_pipe_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output ezq_pipe_t dn_data
);

  localparam logic signed [33:0] ATAN = ezq_atan(STAGE);

  logic      valid_r;
  ezq_pipe_t data_r, data_nxt;

  // Take a new word when empty or when the neighbor takes ours
  assign up_ready = !valid_r || dn_ready;

  // Rotate toward zero residual angle
  always_comb begin
    data_nxt = up_data;
    for (int k = 0; k < 3; k++) begin
      if (!up_data.rot[k].z[33]) begin
        data_nxt.rot[k].x = up_data.rot[k].x - (up_data.rot[k].y >>> STAGE);
        data_nxt.rot[k].y = up_data.rot[k].y + (up_data.rot[k].x >>> STAGE);
        data_nxt.rot[k].z = up_data.rot[k].z - ATAN;
      end else begin
        data_nxt.rot[k].x = up_data.rot[k].x + (up_data.rot[k].y >>> STAGE);
        data_nxt.rot[k].y = up_data.rot[k].y - (up_data.rot[k].x >>> STAGE);
        data_nxt.rot[k].z = up_data.rot[k].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== hw/rtl/ezq_quat.sv =====
// Rounding of sines and cosines, product tree and Q14 saturation.
`timescale 1ns / 1ps
module ezq_quat
  import ezq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  ezq_pipe_t          up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic [2:0][31:0]   dn_pos,
  output logic signed [15:0] dn_qx,
  output logic signed [15:0] dn_qy,
  output logic signed [15:0] dn_qz,
  output logic signed [15:0] dn_qw
);

  localparam int unsigned NSTG = 4;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] ld;

  logic [2:0][31:0] pos1_r, pos2_r, pos3_r, pos4_r;
  // index 0 roll, 1 pitch, 2 yaw
  logic signed [2:0][17:0] c_r, s_r;
  logic signed [17:0] cy2_r, sy2_r;
  logic signed [35:0] cc_r, ss_r, sc_r, cs_r;
  logic signed [53:0] p_r [8];
  logic signed [15:0] qx_r, qy_r, qz_r, qw_r;

  logic signed [2:0][17:0] c_nxt, s_nxt;
  logic signed [15:0] qx_nxt, qy_nxt, qz_nxt, qw_nxt;

  // Ready ripples back from the output register
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || dn_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    ld[0] = rdy[0] && up_valid;
    for (int k = 1; k < NSTG; k++) begin
      ld[k] = rdy[k] && v_r[k-1];
    end
  end
  assign up_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Apply quadrant sign and round to Q15
  always_comb begin
    logic signed [33:0] cx, sy;
    for (int k = 0; k < 3; k++) begin
      cx = up_data.rot[k].neg ? -34'(up_data.rot[k].x) : 34'(up_data.rot[k].x);
      sy = up_data.rot[k].neg ? -34'(up_data.rot[k].y) : 34'(up_data.rot[k].y);
      c_nxt[k] = 18'((cx + 34'sd16384) >>> 15);
      s_nxt[k] = 18'((sy + 34'sd16384) >>> 15);
    end
  end

  // Round Q45 sums to Q14 and clamp
  function automatic logic signed [15:0] sat_q14(input logic signed [54:0] acc);
    logic signed [54:0] v;
    v = (acc + 55'sd1073741824) >>> 31;
    if (v > 55'sd16384) begin
      return 16'sd16384;
    end else if (v < -55'sd16384) begin
      return -16'sd16384;
    end
    return 16'(v);
  endfunction

  always_comb begin
    qx_nxt = sat_q14(55'(p_r[2]) - 55'(p_r[3]));
    qy_nxt = sat_q14(55'(p_r[4]) + 55'(p_r[5]));
    qz_nxt = sat_q14(55'(p_r[6]) - 55'(p_r[7]));
    qw_nxt = sat_q14(55'(p_r[0]) + 55'(p_r[1]));
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      pos1_r <= up_data.pos;
      c_r    <= c_nxt;
      s_r    <= s_nxt;
    end
    // Pair products of roll and pitch terms
    if (ld[1]) begin
      pos2_r <= pos1_r;
      cc_r   <= $signed(c_r[0]) * $signed(c_r[1]);
      ss_r   <= $signed(s_r[0]) * $signed(s_r[1]);
      sc_r   <= $signed(s_r[0]) * $signed(c_r[1]);
      cs_r   <= $signed(c_r[0]) * $signed(s_r[1]);
      cy2_r  <= c_r[2];
      sy2_r  <= s_r[2];
    end
    // Triple products with yaw terms
    if (ld[2]) begin
      pos3_r <= pos2_r;
      p_r[0] <= cc_r * cy2_r;
      p_r[1] <= ss_r * sy2_r;
      p_r[2] <= sc_r * cy2_r;
      p_r[3] <= cs_r * sy2_r;
      p_r[4] <= cs_r * cy2_r;
      p_r[5] <= sc_r * sy2_r;
      p_r[6] <= cc_r * sy2_r;
      p_r[7] <= ss_r * cy2_r;
    end
    if (ld[3]) begin
      pos4_r <= pos3_r;
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
      qz_r   <= qz_nxt;
      qw_r   <= qw_nxt;
    end
  end

  assign dn_valid = v_r[NSTG-1];
  assign dn_pos   = pos4_r;
  assign dn_qx    = qx_r;
  assign dn_qy    = qy_r;
  assign dn_qz    = qz_r;
  assign dn_qw    = qw_r;

`ifndef NO_ASSERTIONS
  // The x and w output components stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    dn_valid |-> (qx_r <= 16'sd16384 && qx_r >= -16'sd16384 &&
                  qw_r <= 16'sd16384 && qw_r >= -16'sd16384))
    else $error("quaternion component out of range");
  // A stalled output register keeps its word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (dn_valid && !dn_ready) |=> (dn_valid && $stable(qw_r) && $stable(pos4_r)))
    else $error("output word changed while stalled");
  // The final stage loads only from a valid predecessor
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    ld[3] |-> v_r[2])
    else $error("final stage loaded from empty stage");
`endif

endmodule

// ===== hw/rtl/euler_zyx_to_quaternion.sv =====
// Top level: Z-Y-X Euler angles to unit quaternion, pose words passed through.
//
//   channel   dir  contents
//   in_pose   in   pos_x/y/z, roll/pitch/yaw angle (Q2.13 at 16 bits)
//   out_pose  out  out_pos_x/y/z, quat_x/y/z/w (Q1.14)
//
// One word per cycle while out_pose is ready; the registers are the fold
// register, one cell per CORDIC stage, round, pair product, triple product, saturate.
// Synchronous active-low reset clears the valid bits only.
// Each stage stalls only when its successor is full and stalled.
`timescale 1ns / 1ps
module euler_zyx_to_quaternion
  import ezq_pkg::*;
#(
  parameter int unsigned ANGLE_WIDTH   = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input logic clk,
  input logic rst_n,
  ezq_in_if.sink    in_pose,
  ezq_out_if.source out_pose
);

  logic      pre_valid_r;
  ezq_pipe_t pre_r, pre_nxt;

  logic      ch_valid [CORDIC_STAGES+1];
  logic      ch_ready [CORDIC_STAGES+1];
  ezq_pipe_t ch_data  [CORDIC_STAGES+1];

  logic [2:0][31:0] q_pos;

  // Scale to Q30 half angle and fold into [-pi/2, pi/2]
  always_comb begin
    logic signed [33:0] z;
    logic signed [ANGLE_WIDTH-1:0] a;
    pre_nxt.pos[0] = in_pose.pos_x;
    pre_nxt.pos[1] = in_pose.pos_y;
    pre_nxt.pos[2] = in_pose.pos_z;
    for (int k = 0; k < 3; k++) begin
      a = (k == 0) ? in_pose.roll_angle : (k == 1) ? in_pose.pitch_angle : in_pose.yaw_angle;
      z = 34'(a) <<< (32 - ANGLE_WIDTH);
      pre_nxt.rot[k].x   = Q30_GAIN;
      pre_nxt.rot[k].y   = '0;
      pre_nxt.rot[k].neg = 1'b0;
      pre_nxt.rot[k].z   = z;
      if (z > Q30_HALF_PI) begin
        pre_nxt.rot[k].z   = z - Q30_PI;
        pre_nxt.rot[k].neg = 1'b1;
      end else if (z < -Q30_HALF_PI) begin
        pre_nxt.rot[k].z   = z + Q30_PI;
        pre_nxt.rot[k].neg = 1'b1;
      end
    end
  end

  assign in_pose.ready = !pre_valid_r || ch_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else if (in_pose.ready) begin
      pre_valid_r <= in_pose.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pose.ready && in_pose.valid) begin
      pre_r <= pre_nxt;
    end
  end

  assign ch_valid[0] = pre_valid_r;
  assign ch_data[0]  = pre_r;

  // CORDIC chain, one cell per stage
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    ezq_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ch_valid[g]),
      .up_ready (ch_ready[g]),
      .up_data  (ch_data[g]),
      .dn_valid (ch_valid[g+1]),
      .dn_ready (ch_ready[g+1]),
      .dn_data  (ch_data[g+1])
    );
  end

  ezq_quat u_quat (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ch_valid[CORDIC_STAGES]),
    .up_ready (ch_ready[CORDIC_STAGES]),
    .up_data  (ch_data[CORDIC_STAGES]),
    .dn_valid (out_pose.valid),
    .dn_ready (out_pose.ready),
    .dn_pos   (q_pos),
    .dn_qx    (out_pose.quat_x),
    .dn_qy    (out_pose.quat_y),
    .dn_qz    (out_pose.quat_z),
    .dn_qw    (out_pose.quat_w)
  );

  assign out_pose.out_pos_x = q_pos[0];
  assign out_pose.out_pos_y = q_pos[1];
  assign out_pose.out_pos_z = q_pos[2];

`ifndef NO_ASSERTIONS
  // Folded roll half angle stays within the CORDIC convergence range
  a_fold: assert property (@(posedge clk) disable iff (!rst_n)
    pre_valid_r |-> (pre_r.rot[0].z <= Q30_HALF_PI && pre_r.rot[0].z >= -Q30_HALF_PI))
    else $error("folded angle outside range");
  // Fold register does not drop a word when the chain is stalled
  a_pre_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pre_valid_r && !ch_ready[0]) |=> (pre_valid_r && $stable(pre_r)))
    else $error("fold register lost a word");
  // Input is taken whenever the fold register is empty
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !pre_valid_r |-> in_pose.ready)
    else $error("input stalled with empty fold register");
`endif

endmodule
